@@ src/slu_pkg.sv @@
// Shared types and constants of the slice linear upsampler.
// Used by slu_recip_div, slice_linear_upsampler and tb_top; no dependencies.
`default_nettype none

package slu_pkg;

  // default limits of the slice size and of the factor
  localparam int unsigned DEF_MAX_SLICE_PIXELS = 262144;
  localparam int unsigned DEF_MAX_FACTOR       = 16;

  // field widths
  localparam int unsigned VOX_W  = 16;  // input voxel
  localparam int unsigned VAL_W  = 24;  // Q.8 result value
  localparam int unsigned OSL_W  = 14;  // output slice index
  localparam int unsigned PIXO_W = 18;  // pixel index on the result
  localparam int unsigned SLC_W  = 10;  // input slice counter
  localparam int unsigned NSL_W  = 11;  // num_slices register
  localparam int unsigned SP_W   = 19;  // slice_pixels register
  localparam int unsigned FACR_W = 5;   // factor register
  localparam int unsigned FAC_W  = 6;   // clamped factor, holds up to 63

  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned M_TDATA_W = 56;

  // divider widths: dividend is (v - prev) * 256
  localparam int unsigned DIV_W       = 25;
  localparam int unsigned X_W         = 24;
  localparam int unsigned QUO_W       = 26;
  localparam int unsigned RECIP_SHIFT = X_W + FAC_W;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned FAC_CODES   = 1 << FAC_W;

  // apb register file
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [1:0] REG_FACTOR       = 2'd0;
  localparam logic [1:0] REG_SLICE_PIXELS = 2'd1;
  localparam logic [1:0] REG_NUM_SLICES   = 2'd2;

  localparam logic [FACR_W-1:0] RST_FACTOR       = 5'd4;
  localparam logic [SP_W-1:0]   RST_SLICE_PIXELS = 19'd262144;
  localparam logic [NSL_W-1:0]  RST_NUM_SLICES   = 11'd1024;
  localparam logic [NSL_W-1:0]  MAX_SLICES       = 11'd1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_EMIT
  } state_e;

  typedef enum logic {
    PH_INTERP,
    PH_COPY
  } phase_e;

  // floor quotient and remainder of the divider
  typedef struct packed {
    logic signed [QUO_W-1:0] quo;
    logic [FAC_W-1:0]        rem;
  } div_res_t;

endpackage

`default_nettype wire

@@ src/slu_store.sv @@
// Slice store: single-port synchronous memory, read-before-write, registered read data.
// Depends on nothing; depth and address width come from the top level.
`default_nettype none

module slu_store #(
  parameter int unsigned DEPTH  = 262144,
  parameter int unsigned ADDR_W = 18,
  parameter int unsigned DATA_W = 16
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // old entry comes out while the new one goes in
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/slu_recip_div.sv @@
// Floor division of a signed 25-bit dividend by the factor, via a reciprocal table.
// Four-stage pipeline, one operation in flight; uses slu_pkg.
`default_nettype none

module slu_recip_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [slu_pkg::DIV_W-1:0] dividend_i,
  input  wire logic [slu_pkg::FAC_W-1:0]     divisor_i,
  output logic                               done_o,
  output slu_pkg::div_res_t                  res_o
);
  import slu_pkg::*;

  logic [RECIP_W-1:0] recip_tbl [FAC_CODES];

  // ceil(2^shift / d): exact quotient for any dividend below 2^X_W
  for (genvar g = 0; g < FAC_CODES; g++) begin : g_recip
    localparam longint unsigned Den = (g == 0) ? 1 : g;
    localparam longint unsigned Rv  = ((64'd1 << RECIP_SHIFT) + Den - 1) / Den;
    assign recip_tbl[g] = RECIP_W'(Rv);
  end

  logic [3:0] vld_q;
  logic [X_W-1:0] x1_q, x2_q, x3_q;
  logic neg1_q, neg2_q, neg3_q;
  logic [X_W+RECIP_W-1:0] prod_q;
  logic [X_W-1:0] qa_q;
  logic [FAC_W-1:0] ra_q;
  div_res_t res_q;

  logic [DIV_W-1:0] neg_d;
  logic [X_W-1:0] qa_d;
  logic [X_W+FAC_W-1:0] back_d;
  logic [X_W+FAC_W-1:0] ra_d;
  logic signed [QUO_W-1:0] qa_ext;

  assign neg_d  = -dividend_i;
  assign qa_d   = prod_q[RECIP_SHIFT +: X_W];
  assign back_d = (X_W + FAC_W)'(qa_d) * (X_W + FAC_W)'(divisor_i);
  assign ra_d   = (X_W + FAC_W)'(x2_q) - back_d;
  assign qa_ext = $signed(QUO_W'(qa_q));

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  // magnitude, reciprocal product, unsigned quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg1_q <= dividend_i[DIV_W-1];
      x1_q   <= dividend_i[DIV_W-1] ? neg_d[X_W-1:0] : dividend_i[X_W-1:0];
    end
    if (vld_q[0]) begin
      prod_q <= (X_W + RECIP_W)'(x1_q) * (X_W + RECIP_W)'(recip_tbl[divisor_i]);
      x2_q   <= x1_q;
      neg2_q <= neg1_q;
    end
    if (vld_q[1]) begin
      qa_q   <= qa_d;
      ra_q   <= ra_d[FAC_W-1:0];
      x3_q   <= x2_q;
      neg3_q <= neg2_q;
    end
    // turn the magnitude result into a floor result
    if (vld_q[2]) begin
      if (!neg3_q) begin
        res_q.quo <= qa_ext;
        res_q.rem <= ra_q;
      end else if (ra_q == '0) begin
        res_q.quo <= -qa_ext;
        res_q.rem <= '0;
      end else begin
        res_q.quo <= -qa_ext - QUO_W'(1);
        res_q.rem <= divisor_i - ra_q;
      end
    end
  end

  assign done_o = vld_q[3];
  assign res_o  = res_q;

  // one operation in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld_q))
    else $error("divider pipeline holds more than one operation");

  a_start_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (vld_q == '0))
    else $error("divider started while busy");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_q.rem < divisor_i))
    else $error("divider remainder not below divisor");

  a_mag_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (ra_q < divisor_i) && (x3_q >= qa_q))
    else $error("reciprocal quotient off by one");

endmodule

`default_nettype wire

@@ src/slice_linear_upsampler.sv @@
// Slice linear upsampler top level: apb registers, counters, sequencer and result register.
// Instantiates slu_store and slu_recip_div; uses slu_pkg.
//
//  channel   dir  handshake                 contents
//  s_axis    in   tvalid/tready             tdata[15:0] voxel
//  m_axis    out  tvalid/tready             tdata: value, out_slice, pixel_index; tlast run_last
//  apb       in   psel/penable/pwrite       factor @0x0, slice_pixels @0x4, num_slices @0x8
//
// An item of slice 1 and later gives n results (factor, or twice factor on the last slice):
// store read, four divider stages, then one result a cycle while m_axis does not stall.
// An item of the first slice gives no result and leaves the sequencer idle; of a single-slice volume, factor copies.
// The store is one single-port memory, read and written once per item at the pixel address.
// Reset clears counters and state, sets register defaults; store stays undefined until written.
// A stalled m_axis holds the sequencer; the last result waits in the output register while
// the next voxel is taken.
`default_nettype none

module slice_linear_upsampler #(
  parameter int unsigned MAX_SLICE_PIXELS = slu_pkg::DEF_MAX_SLICE_PIXELS,
  parameter int unsigned MAX_FACTOR       = slu_pkg::DEF_MAX_FACTOR
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // voxel stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [slu_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [15:0] voxel
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [slu_pkg::M_TDATA_W-1:0]      m_axis_tdata,   // [23:0] value, [37:24] out_slice,
                                                             // [55:38] pixel_index
  output logic                               m_axis_tlast,   // run_last
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [slu_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [slu_pkg::DATA_W-1:0]    pwdata,
  output logic [slu_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import slu_pkg::*;

  localparam int unsigned PIX_W = (MAX_SLICE_PIXELS > 1) ? $clog2(MAX_SLICE_PIXELS) : 1;
  localparam int unsigned CMP_W = (PIX_W + 1 > SP_W) ? PIX_W + 1 : SP_W;

  // configuration registers
  logic [FACR_W-1:0] factor_q;
  logic [SP_W-1:0]   slice_pixels_q;
  logic [NSL_W-1:0]  num_slices_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q       <= RST_FACTOR;
      slice_pixels_q <= RST_SLICE_PIXELS;
      num_slices_q   <= RST_NUM_SLICES;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FACTOR:       factor_q       <= pwdata[FACR_W-1:0];
        REG_SLICE_PIXELS: slice_pixels_q <= pwdata[SP_W-1:0];
        REG_NUM_SLICES:   num_slices_q   <= pwdata[NSL_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_FACTOR:       prdata = DATA_W'(factor_q);
      REG_SLICE_PIXELS: prdata = DATA_W'(slice_pixels_q);
      REG_NUM_SLICES:   prdata = DATA_W'(num_slices_q);
      default:          prdata = '0;
    endcase
  end

  // saturated register values
  logic [FAC_W-1:0] fac_c;
  logic [CMP_W-1:0] sp_c;
  logic [NSL_W-1:0] ns_c;

  always_comb begin
    if (factor_q == '0) begin
      fac_c = FAC_W'(1);
    end else if (FAC_W'(factor_q) > FAC_W'(MAX_FACTOR)) begin
      fac_c = FAC_W'(MAX_FACTOR);
    end else begin
      fac_c = FAC_W'(factor_q);
    end
    if (slice_pixels_q == '0) begin
      sp_c = CMP_W'(1);
    end else if (CMP_W'(slice_pixels_q) > CMP_W'(MAX_SLICE_PIXELS)) begin
      sp_c = CMP_W'(MAX_SLICE_PIXELS);
    end else begin
      sp_c = CMP_W'(slice_pixels_q);
    end
    if (num_slices_q == '0) begin
      ns_c = NSL_W'(1);
    end else if (num_slices_q > MAX_SLICES) begin
      ns_c = MAX_SLICES;
    end else begin
      ns_c = num_slices_q;
    end
  end

  // pixel and slice counters
  logic [PIX_W-1:0] cnt_q;
  logic [SLC_W-1:0] slc_q;
  logic [PIX_W:0]   cnt_inc;
  logic [NSL_W-1:0] slc_inc;
  logic             last_c;
  logic             in_xfer;
  state_e           state_q, state_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign cnt_inc       = {1'b0, cnt_q} + (PIX_W + 1)'(1);
  assign slc_inc       = {1'b0, slc_q} + NSL_W'(1);
  assign last_c        = (slc_inc >= ns_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      slc_q <= '0;
    end else if (in_xfer) begin
      if (CMP_W'(cnt_inc) >= sp_c) begin
        cnt_q <= '0;
        slc_q <= last_c ? '0 : slc_inc[SLC_W-1:0];
      end else begin
        cnt_q <= cnt_inc[PIX_W-1:0];
      end
    end
  end

  // slice store, read and written on every voxel transfer
  logic [VOX_W-1:0] prev;

  slu_store #(
    .DEPTH  (MAX_SLICE_PIXELS),
    .ADDR_W (PIX_W),
    .DATA_W (VOX_W)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (in_xfer),
    .we_i    (in_xfer),
    .addr_i  (cnt_q),
    .wdata_i (s_axis_tdata[VOX_W-1:0]),
    .rdata_o (prev)
  );

  // item registers
  logic [VOX_W-1:0] voxel_q;
  logic [PIX_W-1:0] pix_q;
  logic [SLC_W-1:0] slice_cur_q;
  logic             last_q;
  logic [FAC_W-1:0] fac_q;

  // difference times 256 goes to the divider
  logic signed [VOX_W:0]   diff_c;
  logic signed [DIV_W-1:0] dvd_c;
  logic                    div_start, div_done;
  div_res_t                div_res;

  assign diff_c = $signed({voxel_q[VOX_W-1], voxel_q}) - $signed({prev[VOX_W-1], prev});
  assign dvd_c  = {diff_c, 8'h00};

  slu_recip_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_c),
    .divisor_i  (fac_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  // emission state
  phase_e                  phase_q;
  logic [FAC_W-1:0]        f_q;
  logic signed [QUO_W-1:0] acc_q;
  logic [FAC_W-1:0]        accr_q;
  logic [OSL_W-1:0]        oslc_q;
  logic [15:0]             base_c;
  logic [FAC_W:0]          accr_sum;
  logic                    accr_wrap;
  logic                    f_end;
  logic                    out_free;
  logic                    emit;
  logic                    out_last;
  logic signed [QUO_W-1:0] interp_sum;
  logic [VAL_W-1:0]        out_val;

  assign base_c     = 16'(slice_cur_q - SLC_W'(1)) * 16'(fac_q);
  assign accr_sum   = {1'b0, accr_q} + {1'b0, div_res.rem};
  assign accr_wrap  = (accr_sum >= {1'b0, fac_q});
  assign f_end      = (f_q == fac_q - FAC_W'(1));
  assign out_last   = f_end & ((phase_q == PH_COPY) | ~last_q);
  assign interp_sum = $signed({{2{prev[VOX_W-1]}}, prev, 8'h00}) + acc_q;
  assign out_val    = (phase_q == PH_INTERP) ? interp_sum[VAL_W-1:0] : {voxel_q, 8'h00};

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and strobes
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    emit      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (slc_q != '0) begin
            state_d = ST_READ;
          end else if (last_c) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_READ: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (out_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      voxel_q     <= s_axis_tdata[VOX_W-1:0];
      pix_q       <= cnt_q;
      slice_cur_q <= slc_q;
      last_q      <= last_c;
      fac_q       <= fac_c;
    end
  end

  // per-result walk: f, output slice, running floor quotient and remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_INTERP;
      f_q     <= '0;
      acc_q   <= '0;
      accr_q  <= '0;
      oslc_q  <= '0;
    end else begin
      if (in_xfer) begin
        phase_q <= PH_COPY;
        f_q     <= '0;
        oslc_q  <= '0;
      end
      if (state_q == ST_READ) begin
        oslc_q <= base_c[OSL_W-1:0];
      end
      if ((state_q == ST_WAIT) && div_done) begin
        phase_q <= PH_INTERP;
        f_q     <= '0;
        acc_q   <= '0;
        accr_q  <= '0;
      end
      if (emit) begin
        oslc_q <= oslc_q + OSL_W'(1);
        if (accr_wrap) begin
          accr_q <= accr_sum[FAC_W-1:0] - fac_q;
          acc_q  <= acc_q + div_res.quo + QUO_W'(1);
        end else begin
          accr_q <= accr_sum[FAC_W-1:0];
          acc_q  <= acc_q + div_res.quo;
        end
        if (f_end) begin
          f_q     <= '0;
          phase_q <= PH_COPY;
        end else begin
          f_q <= f_q + FAC_W'(1);
        end
      end
    end
  end

  // result register
  logic                 m_valid_q;
  logic [VAL_W-1:0]     m_val_q;
  logic [OSL_W-1:0]     m_slc_q;
  logic [PIXO_W-1:0]    m_pix_q;
  logic                 m_last_q;

  assign out_free = ~m_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_val_q  <= out_val;
      m_slc_q  <= oslc_q;
      m_pix_q  <= PIXO_W'(pix_q);
      m_last_q <= out_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_pix_q, m_slc_q, m_val_q};
  assign m_axis_tlast  = m_last_q;

  // checks
  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT))
    else $error("divider result arrived outside the wait state");

  // running remainder only matters while interpolating
  a_f_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (f_q < fac_q) && ((phase_q == PH_COPY) || (accr_q < fac_q)))
    else $error("emission counters out of range");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_last) |=> (state_q == ST_IDLE) && m_axis_tvalid && m_axis_tlast)
    else $error("final result did not return the sequencer to idle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(cnt_q) < CMP_W'(MAX_SLICE_PIXELS))
    else $error("pixel counter beyond store depth");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for the slice linear upsampler: voxel stream in, interpolated slices out.
// Keeps its own slice store, counters and register copy to work out every result.
// Depends on slu_pkg and slice_linear_upsampler.
`default_nettype none

module tb_top;
  import slu_pkg::*;

  localparam int unsigned STORE_DEPTH  = DEF_MAX_SLICE_PIXELS;
  localparam int unsigned FAC_MAX      = DEF_MAX_FACTOR;
  localparam int unsigned NS_MAX       = 1024;
  localparam int          RANDOM_ITEMS = 300;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          QUIET_LIMIT  = 2000;

  typedef enum {ROW_WRITE, ROW_VOXEL} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [1:0]         reg_idx;
    logic [DATA_W-1:0]  data;      // register value or voxel
    bit                 typed;     // count and value listed below
    int                 n_typed;
    logic [VAL_W-1:0]   v_typed;
  } stim_row_t;

  typedef struct {
    logic [VAL_W-1:0]  value;
    logic [OSL_W-1:0]  out_slice;
    logic [PIXO_W-1:0] pixel;
    logic              run_last;
  } out_voxel_t;

  // dut signals
  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // [15:0] voxel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // [23:0] value, [37:24] out_slice, [55:38] pixel_index
  logic                 m_axis_tlast;   // run_last
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  slice_linear_upsampler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // shadow of the block state
  bit   [VOX_W-1:0]  prev_slice_mem [STORE_DEPTH];
  int unsigned       pix_cnt;
  int unsigned       slc_cnt;
  logic [FACR_W-1:0] fac_reg;
  logic [SP_W-1:0]   sp_reg;
  logic [NSL_W-1:0]  ns_reg;

  out_voxel_t out_voxel_q [$];

  bit calm;            // no idling on either side
  int stall_left   = 0;
  int quiet_cycles = 0;
  int mismatch_cnt = 0;
  int voxels_fed   = 0;
  int results_seen = 0;
  int volumes_done = 0;
  int writes_done  = 0;

  // directed rows: reset state, field extremes, clamping, max results, mid-volume change
  stim_row_t dir_rows [0:28] = '{
    '{ROW_VOXEL, REG_FACTOR,       32'h0000,  1'b1, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'h7FFF,  1'b1, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'h8000,  1'b1, 0,  24'h000000},
    '{ROW_WRITE, REG_NUM_SLICES,   32'd0,     1'b0, 0,  24'h000000},
    '{ROW_WRITE, REG_SLICE_PIXELS, 32'h7FFFF, 1'b0, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'h7FFF,  1'b1, 4,  24'h7FFF00},
    '{ROW_VOXEL, REG_FACTOR,       32'h8000,  1'b1, 4,  24'h800000},
    '{ROW_WRITE, REG_SLICE_PIXELS, 32'd1,     1'b0, 0,  24'h000000},
    '{ROW_WRITE, REG_FACTOR,       32'd0,     1'b0, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'hFFFF,  1'b1, 1,  24'hFFFF00},
    '{ROW_VOXEL, REG_FACTOR,       32'h0001,  1'b1, 1,  24'h000100},
    '{ROW_WRITE, REG_FACTOR,       32'd31,    1'b0, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'h1234,  1'b1, 16, 24'h123400},
    '{ROW_WRITE, REG_NUM_SLICES,   32'd2,     1'b0, 0,  24'h000000},
    '{ROW_WRITE, REG_SLICE_PIXELS, 32'd2,     1'b0, 0,  24'h000000},
    '{ROW_WRITE, REG_FACTOR,       32'd16,    1'b0, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'h8000,  1'b1, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'h7FFF,  1'b1, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'h7FFF,  1'b0, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'h8000,  1'b0, 0,  24'h000000},
    '{ROW_WRITE, REG_NUM_SLICES,   32'd2047,  1'b0, 0,  24'h000000},
    '{ROW_WRITE, REG_FACTOR,       32'd3,     1'b0, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'h0064,  1'b1, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'hFF9C,  1'b1, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'hFFF9,  1'b0, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'h0005,  1'b0, 0,  24'h000000},
    '{ROW_WRITE, REG_NUM_SLICES,   32'd2,     1'b0, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'h5555,  1'b0, 0,  24'h000000},
    '{ROW_VOXEL, REG_FACTOR,       32'hAAAA,  1'b0, 0,  24'h000000}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // register values as the block uses them
  function automatic int unsigned clamp_u(int unsigned x, int unsigned lo, int unsigned hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic int unsigned fac_eff();
    return clamp_u(fac_reg, 1, FAC_MAX);
  endfunction

  function automatic int unsigned sp_eff();
    return clamp_u(sp_reg, 1, STORE_DEPTH);
  endfunction

  function automatic int unsigned ns_eff();
    return clamp_u(ns_reg, 1, NS_MAX);
  endfunction

  // results of one voxel; updates the slice store and the counters
  function automatic void interpolate_voxel(input logic [VOX_W-1:0] raw,
                                            output out_voxel_t res [$]);
    int unsigned fac;
    int unsigned pix;
    int unsigned s;
    int unsigned f;
    longint      v;
    longint      prev;
    longint      num;
    longint      q;
    bit          last_slice;
    out_voxel_t  r;
    fac        = fac_eff();
    v          = $signed(raw);
    pix        = pix_cnt % STORE_DEPTH;
    s          = slc_cnt;
    last_slice = (s + 1 >= ns_eff());
    res        = {};
    // interpolated slices between the stored slice and this one
    if (s >= 1) begin
      prev = $signed(prev_slice_mem[pix]);
      for (f = 0; f < fac; f++) begin
        num = (v - prev) * longint'(f) * 256;
        q   = num / longint'(fac);
        if ((num % longint'(fac)) != 0 && num < 0) q--;
        r.value     = VAL_W'(prev * 256 + q);
        r.out_slice = OSL_W'((s - 1) * fac + f);
        r.pixel     = PIXO_W'(pix);
        r.run_last  = 1'b0;
        res.push_back(r);
      end
    end
    // copies of the last slice
    if (last_slice) begin
      for (f = 0; f < fac; f++) begin
        r.value     = VAL_W'(v * 256);
        r.out_slice = OSL_W'(s * fac + f);
        r.pixel     = PIXO_W'(pix);
        r.run_last  = 1'b0;
        res.push_back(r);
      end
    end
    if (res.size() > 0) res[res.size() - 1].run_last = 1'b1;
    prev_slice_mem[pix] = raw;
    // advance pixel and slice, wrap at end of volume
    pix_cnt++;
    if (pix_cnt >= sp_eff()) begin
      pix_cnt = 0;
      if (last_slice) begin
        slc_cnt = 0;
        volumes_done++;
      end else begin
        slc_cnt = (slc_cnt + 1) & 32'h3FF;
      end
    end
  endfunction

  // idle lengths: mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 99) < 55) return 0;
    return idle_len();
  endfunction

  function automatic logic [VOX_W-1:0] pick_voxel();
    int               r;
    logic [VOX_W-1:0] near;
    r    = $urandom_range(0, 99);
    near = prev_slice_mem[pix_cnt % STORE_DEPTH];
    if (r < 4)  return 16'h8000;
    if (r < 8)  return 16'h7FFF;
    if (r < 11) return 16'h0000;
    if (r < 14) return 16'hFFFF;
    // smooth volume: small step from the stored voxel
    if (r < 40) return near + VOX_W'($urandom_range(0, 64)) - VOX_W'(32);
    return VOX_W'($urandom());
  endfunction

  function automatic int unsigned pick_factor();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return 0;
    if (r < 12) return $urandom_range(17, 31);
    if (r < 25) return 1;
    if (r < 40) return 16;
    return $urandom_range(2, 15);
  endfunction

  function automatic int unsigned pick_sp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return 0;
    if (r < 80) return $urandom_range(1, 6);
    return $urandom_range(7, 24);
  endfunction

  function automatic int unsigned pick_ns();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return 0;
    if (r < 75) return $urandom_range(1, 4);
    return $urandom_range(5, 8);
  endfunction

  // one voxel transfer on the input stream
  task automatic send_voxel(input logic [VOX_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // send a voxel and queue what it should produce
  task automatic feed_voxel(input logic [VOX_W-1:0] v, input bit typed, input int n_typed,
                            input logic [VAL_W-1:0] v_typed);
    out_voxel_t res [$];
    send_voxel(v);
    interpolate_voxel(v, res);
    if (typed) begin
      if (res.size() != n_typed) begin
        $error("directed voxel %h: %0d results listed, %0d worked out", v, n_typed, res.size());
        mismatch_cnt++;
      end
      foreach (res[i]) res[i].value = v_typed;
    end
    foreach (res[i]) out_voxel_q.push_back(res[i]);
    voxels_fed++;
  endtask

  task automatic wait_drained();
    while (out_voxel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // apb setup and access phases, then idle with psel low
  task automatic apb_transfer(input bit wr, input logic [1:0] idx,
                              input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // register write with read-back
  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] want;
    apb_transfer(1'b1, idx, val, rd);
    case (idx)
      REG_FACTOR: begin
        fac_reg = FACR_W'(val);
        want    = DATA_W'(fac_reg);
      end
      REG_SLICE_PIXELS: begin
        sp_reg = SP_W'(val);
        want   = DATA_W'(sp_reg);
      end
      default: begin
        ns_reg = NSL_W'(val);
        want   = DATA_W'(ns_reg);
      end
    endcase
    apb_transfer(1'b0, idx, '0, rd);
    if (rd !== want) begin
      $error("prdata of register %0d: expected %h, got %h", idx, want, rd);
      mismatch_cnt++;
    end
    writes_done++;
  endtask

  // one random volume, sometimes with a register change partway through
  task automatic run_random_volume();
    int unsigned vol;
    int unsigned k;
    int          r;
    calm = ($urandom_range(0, 99) < 20);
    cfg_write(REG_FACTOR, pick_factor());
    cfg_write(REG_SLICE_PIXELS, pick_sp());
    cfg_write(REG_NUM_SLICES, pick_ns());
    vol = sp_eff() * ns_eff();
    if (vol > 1 && $urandom_range(0, 99) < 25) begin
      k = $urandom_range(1, vol - 1);
      repeat (k) feed_voxel(pick_voxel(), 1'b0, 0, '0);
      s_axis_tvalid <= 1'b0;
      wait_drained();
      // slice_pixels never grows here so every stored pixel read was written
      r = $urandom_range(0, 2);
      if (r == 0)      cfg_write(REG_FACTOR, pick_factor());
      else if (r == 1) cfg_write(REG_NUM_SLICES, $urandom_range(1, 6));
      else             cfg_write(REG_SLICE_PIXELS, $urandom_range(1, sp_eff()));
    end
    do feed_voxel(pick_voxel(), 1'b0, 0, '0); while (pix_cnt != 0 || slc_cnt != 0);
    s_axis_tvalid <= 1'b0;
    wait_drained();
  endtask

  // result stream backpressure
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left = idle_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    out_voxel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (out_voxel_q.size() == 0) begin
        $error("result with nothing expected: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        mismatch_cnt++;
      end else begin
        want = out_voxel_q.pop_front();
        if (m_axis_tdata[VAL_W-1:0] !== want.value) begin
          $error("value: expected %h, got %h", want.value, m_axis_tdata[VAL_W-1:0]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[VAL_W +: OSL_W] !== want.out_slice) begin
          $error("out_slice: expected %0d, got %0d", want.out_slice,
                 m_axis_tdata[VAL_W +: OSL_W]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[VAL_W + OSL_W +: PIXO_W] !== want.pixel) begin
          $error("pixel_index: expected %0d, got %0d", want.pixel,
                 m_axis_tdata[VAL_W + OSL_W +: PIXO_W]);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, m_axis_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  // cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("slice_linear_upsampler test failed");
    $finish;
  end

  // stimulus
  initial begin
    int dir_items;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    fac_reg       = RST_FACTOR;
    sp_reg        = RST_SLICE_PIXELS;
    ns_reg        = RST_NUM_SLICES;
    pix_cnt       = 0;
    slc_cnt       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].data);
      end else begin
        feed_voxel(dir_rows[i].data[VOX_W-1:0], dir_rows[i].typed, dir_rows[i].n_typed,
                   dir_rows[i].v_typed);
      end
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
    dir_items = voxels_fed;

    // random volumes
    while (voxels_fed < dir_items + RANDOM_ITEMS) run_random_volume();

    $display("%0d voxels fed (%0d directed) over %0d volumes, %0d register writes",
             voxels_fed, dir_items, volumes_done, writes_done);
    $display("%0d results checked, %0d mismatches", results_seen, mismatch_cnt);
    if (mismatch_cnt == 0 && out_voxel_q.size() == 0)
      $display("slice_linear_upsampler test passed");
    else
      $display("slice_linear_upsampler test failed");
    $finish;
  end

endmodule

`default_nettype wire
